// File: sv/indexed_insert_remove_list_assert.svh
// Assertion macros used by the checker file of the list block.
// Each macro expands to one labelled concurrent assertion on the rising edge of clk,
// with the check switched off while rst is high.
`ifndef INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared constants, operation and status codes, and the command word
// broadcast along the chain of list cells.
// ----------------------------------------------------------------------------
package ilst_pkg;

  // List geometry
  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;

  // Field widths of the ports
  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 5;

  // Derived widths
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT       = 3'd0,
    OP_INSERT_EMPTY = 3'd1,
    OP_REMOVE       = 3'd2,
    OP_READ         = 3'd3,
    OP_CLEAR        = 3'd4
  } op_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Command word seen by every cell
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic                  wr_zero;
    logic [POS_W-1:0]      pos;
    logic [WORD_WIDTH-1:0] value;
  } cmd_t;

endpackage

// File: sv/ilst_cell.sv
// ----------------------------------------------------------------------------
// ilst_cell
// One slot of the list. Takes the word of its lower neighbour on an insert
// above the target, the word of its upper neighbour on a remove at or above
// the target, and adds its word to the read chain when it is the target.
// ----------------------------------------------------------------------------
module ilst_cell (
  input  logic                           clk,
  input  logic [ilst_pkg::IDX_W-1:0]     idx,
  input  ilst_pkg::cmd_t                 cmd,
  input  logic [ilst_pkg::WORD_WIDTH-1:0] lower_word,
  input  logic [ilst_pkg::WORD_WIDTH-1:0] upper_word,
  input  logic [ilst_pkg::WORD_WIDTH-1:0] rd_in,
  output logic [ilst_pkg::WORD_WIDTH-1:0] word,
  output logic [ilst_pkg::WORD_WIDTH-1:0] rd_out
);
  import ilst_pkg::*;

  logic [CMP_W-1:0] idx_x;
  logic [CMP_W-1:0] pos_x;
  logic             hit;
  logic             above;

  // Compare this slot with the target position
  assign idx_x = CMP_W'(idx);
  assign pos_x = CMP_W'(cmd.pos);
  assign hit   = (idx_x == pos_x);
  assign above = (idx_x > pos_x);

  // Merge into the read chain
  assign rd_out = rd_in | (hit ? word : '0);

  // Shift or load the slot
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (above) begin
        word <= lower_word;
      end else if (hit) begin
        word <= cmd.wr_zero ? '0 : cmd.value;
      end
    end else if (cmd.rem) begin
      if (above || hit) begin
        word <= upper_word;
      end
    end
  end

endmodule

// File: sv/ilst_ctrl.sv
// ----------------------------------------------------------------------------
// ilst_ctrl
// Decodes each command word, checks the position against the fill count,
// drives the cell chain and registers the response word.
// ----------------------------------------------------------------------------
module ilst_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic [ilst_pkg::OP_W-1:0]       operation,
  input  logic [ilst_pkg::POS_W-1:0]      position,
  input  logic [ilst_pkg::VALUE_W-1:0]    value,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [ilst_pkg::STAT_W-1:0]     status,
  output logic [ilst_pkg::VALUE_W-1:0]    read_value,
  output logic [ilst_pkg::ECNT_W-1:0]     entry_count,
  input  logic [ilst_pkg::WORD_WIDTH-1:0] rd_word,
  output ilst_pkg::cmd_t                  cmd
);
  import ilst_pkg::*;

  logic             acc;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             full;
  logic             do_ins;
  logic             do_rem;
  logic             do_rd;
  status_t          st;

  // Hold off new words during reset and while a response is stalled
  assign cmd_stall = rst || (rsp_valid && rsp_stall);
  assign acc       = cmd_valid && !cmd_stall;

  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));

  // Decode the operation and check the target position
  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_rd      = 1'b0;
    st         = ST_OK;
    count_next = count;
    unique case (operation) inside
      OP_INSERT, OP_INSERT_EMPTY: begin
        if (pos_x > cnt_x) begin
          st = ST_BAD;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          st = ST_BAD;
        end else begin
          do_rem     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          st = ST_BAD;
        end else begin
          do_rd = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        st = ST_BAD;
      end
    endcase
  end

  // Broadcast the command to the cells
  assign cmd.ins     = acc && do_ins;
  assign cmd.rem     = acc && do_rem;
  assign cmd.wr_zero = (operation == OP_INSERT_EMPTY);
  assign cmd.pos     = position;
  assign cmd.value   = WORD_WIDTH'(value);

  // Advance the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc) begin
      count <= count_next;
    end
  end

  // Register the response word; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status      <= st;
      read_value  <= do_rd ? VALUE_W'(rd_word) : '0;
      entry_count <= ECNT_W'(count_next);
    end
  end

endmodule

// File: sv/indexed_insert_remove_list.sv
// Ordered list of up to CAPACITY words with insert, remove, read and clear.
// Command channel: cmd_valid / cmd_stall carries operation, position and
// value; a word is taken at a rising edge with cmd_valid high and cmd_stall
// low. Response channel: rsp_valid / rsp_stall carries status, read_value
// and entry_count, one response word for every command word.
// The response is registered and follows in the cycle after the command is
// taken. Throughput: one command per cycle unless the response is stalled.
// Every slot is a cell that shifts in parallel with the rest, so an insert or
// remove costs the same at any position; a read selects through the cell chain.
// Reset clears the fill count and the response register; the slot contents
// are not cleared and are only read below the fill count. cmd_stall is high
// during reset.
// When the receiver stalls, the response word holds and cmd_stall rises, so
// no command is taken until the response is taken; a command arriving in the
// cycle the response is taken is accepted at once.
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// Top level: control unit and a row of list cells.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [ilst_pkg::OP_W-1:0]    operation,
  input  logic [ilst_pkg::POS_W-1:0]   position,
  input  logic [ilst_pkg::VALUE_W-1:0] value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [ilst_pkg::STAT_W-1:0]  status,
  output logic [ilst_pkg::VALUE_W-1:0] read_value,
  output logic [ilst_pkg::ECNT_W-1:0]  entry_count
);
  import ilst_pkg::*;

  cmd_t                  cmd;
  logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
  logic [WORD_WIDTH-1:0] rd_chain  [CAPACITY+1];

  // Control and response register
  ilst_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .operation   (operation),
    .position    (position),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count),
    .rd_word     (rd_chain[0]),
    .cmd         (cmd)
  );

  // Read chain starts empty above the top cell
  assign rd_chain[CAPACITY] = '0;

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] lower_word;
    logic [WORD_WIDTH-1:0] upper_word;

    if (i == 0) begin : g_bottom
      assign lower_word = '0;
    end else begin : g_lower
      assign lower_word = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign upper_word = '0;
    end else begin : g_upper
      assign upper_word = cell_word[i+1];
    end

    ilst_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .cmd        (cmd),
      .lower_word (lower_word),
      .upper_word (upper_word),
      .rd_in      (rd_chain[i+1]),
      .word       (cell_word[i]),
      .rd_out     (rd_chain[i])
    );
  end

endmodule

// File: sv/ilst_checker.sv
// ----------------------------------------------------------------------------
// ilst_checker
// Port-level checks on the list block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "indexed_insert_remove_list_assert.svh"

module ilst_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_stall,
  input logic [ilst_pkg::OP_W-1:0]    operation,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input logic [ilst_pkg::STAT_W-1:0]  status,
  input logic [ilst_pkg::VALUE_W-1:0] read_value,
  input logic [ilst_pkg::ECNT_W-1:0]  entry_count
);
  import ilst_pkg::*;

  logic cmd_take;

  assign cmd_take = !rst && cmd_valid && !cmd_stall;

  // A stalled response word holds
  `ILST_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
    rsp_valid && $stable(status) && $stable(read_value) && $stable(entry_count),
    "stalled response changed")

  // Every command word gives a response in the next cycle
  `ILST_ASSERT_NEXT(a_rsp_latency, cmd_take, rsp_valid,
    "no response one cycle after a command")

  // A clear always empties the list with status ok
  `ILST_ASSERT_NEXT(a_clear_empties, cmd_take && (operation == OP_CLEAR),
    (entry_count == ECNT_W'(0)) && (status == ST_OK),
    "clear did not empty the list")

  // Only a successful read returns data
  `ILST_ASSERT_NOW(a_err_no_data, rsp_valid && (status != ST_OK),
    read_value == '0, "read data on a failed command")

  // A full refusal reports a full list
  `ILST_ASSERT_NOW(a_full_count, rsp_valid && (status == ST_FULL),
    entry_count == ECNT_W'(CAPACITY), "full status with list not full")

endmodule

bind indexed_insert_remove_list ilst_checker u_checker (.*);

// File: sim/tb_indexed_insert_remove_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_insert_remove_list
// Self-checking bench for the ordered insert/remove list. A scoreboard keeps
// its own copy of the list and predicts one response word per command word.
// Each response taken is checked field by field against the oldest
// prediction. Directed words cover the edge cases. Random words follow,
// mostly well-formed and steered to grow, shrink or mix the list. The run
// moves through phases with different sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_list;
  import ilst_pkg::*;

  localparam int RESET_CYCLES    = 6;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int PHASES          = 4;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 8;
  localparam int RUN_LIMIT_NS    = 5_000_000;

  // Operation codes the block does not define
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow list plus queue of predicted response words
  // --------------------------------------------------------------------------
  class list_scoreboard;
    typedef struct {
      status_t           status;
      logic [VALUE_W-1:0] read_value;
      logic [ECNT_W-1:0]  entry_count;
    } reply_t;

    logic [WORD_WIDTH-1:0] slots [CAPACITY];
    int unsigned           fill;
    reply_t                awaited [$];
    int                    errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function int pending();
      return awaited.size();
    endfunction

    // Apply one accepted command word to the shadow list and queue the reply
    function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] val);
      reply_t r;
      int     p;
      int     i;
      r.status     = ST_OK;
      r.read_value = '0;
      p            = int'(pos);
      case (op)
        OP_INSERT, OP_INSERT_EMPTY: begin
          if (p > int'(fill)) begin
            r.status = ST_BAD;
          end else if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            // open a gap at the target, then write it
            for (i = int'(fill); i > p; i--)
              slots[i] = slots[i-1];
            slots[p] = (op == OP_INSERT) ? val[WORD_WIDTH-1:0] : '0;
            fill++;
          end
        end
        OP_REMOVE: begin
          if (p >= int'(fill)) begin
            r.status = ST_BAD;
          end else begin
            // close the gap: only the entries above the target move
            for (i = p; i + 1 < int'(fill); i++)
              slots[i] = slots[i+1];
            fill--;
          end
        end
        OP_READ: begin
          if (p >= int'(fill))
            r.status = ST_BAD;
          else
            r.read_value = slots[p];
        end
        OP_CLEAR: begin
          fill = 0;
        end
        default: begin
          r.status = ST_BAD;
        end
      endcase
      r.entry_count = ECNT_W'(fill);
      awaited.push_back(r);
    endfunction

    // Compare one accepted response word with the oldest prediction
    task check_response(logic [STAT_W-1:0] st, logic [VALUE_W-1:0] rd,
                        logic [ECNT_W-1:0] cnt);
      reply_t r;
      if (awaited.size() == 0) begin
        report($sformatf("response word with nothing outstanding (status %0d)", st));
        return;
      end
      r = awaited.pop_front();
      if (st !== r.status)
        report($sformatf("status %0d, predicted %0d", st, r.status));
      if (rd !== r.read_value)
        report($sformatf("read_value %h, predicted %h", rd, r.read_value));
      if (cnt !== r.entry_count)
        report($sformatf("entry_count %0d, predicted %0d", cnt, r.entry_count));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cmd_valid   = 1'b0;
  logic                cmd_stall;
  logic [OP_W-1:0]     operation   = '0;
  logic [POS_W-1:0]    position    = '0;
  logic [VALUE_W-1:0]  value       = '0;
  logic                rsp_valid;
  logic                rsp_stall   = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [VALUE_W-1:0]  read_value;
  logic [ECNT_W-1:0]   entry_count;

  int idle_pct  = 0;
  int stall_pct = 0;

  list_scoreboard sb = new();

  indexed_insert_remove_list uut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .operation   (operation),
    .position    (position),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the response channel at random
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watch both channels on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall)
        sb.check_response(status, read_value, entry_count);
      if (cmd_valid && !cmd_stall)
        sb.note_command(operation, position, value);
    end
  end

  // Offer one command word, starting and ending at a falling edge
  task automatic send(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                      input logic [VALUE_W-1:0] val);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct)
      gap++;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    // hold until the word is taken
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  // Give up on a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_indexed_insert_remove_list failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    int                 fill_now;
    int                 roll;
    int                 waited;
    int                 trend_left;
    trend_t             trend;

    trend      = TREND_GROW;
    trend_left = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list, appends and prepends, bad positions, spare codes
    send(OP_READ,         5'd0,  '0);
    send(OP_REMOVE,       5'd0,  '0);
    send(OP_INSERT,       5'd1,  32'h1234_5678);
    send(OP_INSERT,       5'd0,  '0);
    send(OP_INSERT,       5'd0,  '1);
    send(OP_INSERT_EMPTY, 5'd2,  32'hDEAD_BEEF);
    send(OP_INSERT,       5'd1,  32'hA5A5_5A5A);
    for (int i = 0; i < 4; i++)
      send(OP_READ, POS_W'(i), '0);
    send(OP_READ,         5'd4,  '0);
    send(OP_READ,         '1,    '1);
    send(OP_INSERT,       '1,    '1);
    send(OP_REMOVE,       5'd1,  '0);
    send(OP_REMOVE,       5'd2,  '0);
    send(OP_READ,         5'd1,  '0);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
      send(OP_W'(c), '1, '1);
    send(OP_CLEAR,        5'd0,  '0);
    send(OP_READ,         5'd0,  '0);
    send(OP_REMOVE,       '1,    '0);
    send(OP_INSERT,       5'd0,  32'h0000_0001);
    send(OP_CLEAR,        '1,    '1);

    // Random: phases of sender idling and receiver stalling, each steering the list between trends
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (trend_left == 0) begin
          trend      = trend_t'($urandom_range(2));
          trend_left = $urandom_range(60, 20);
        end
        trend_left--;
        fill_now = int'(sb.fill);

        case ($urandom_range(7))
          0:       val = '0;
          1:       val = '1;
          default: val = $urandom;
        endcase

        roll = $urandom_range(99);
        if (roll < 8) begin
          // noise: any code, any position
          op  = OP_W'($urandom_range(7));
          pos = POS_W'($urandom_range(31));
        end else begin
          roll = $urandom_range(99);
          case (trend)
            TREND_GROW:
              op = (roll < 75) ? OP_INSERT : (roll < 88) ? OP_READ : OP_REMOVE;
            TREND_SHRINK:
              op = (roll < 65) ? OP_REMOVE : (roll < 85) ? OP_READ : OP_INSERT;
            default:
              op = (roll < 30) ? OP_INSERT : (roll < 55) ? OP_REMOVE :
                   (roll < 95) ? OP_READ : OP_CLEAR;
          endcase
          if (op == OP_INSERT && $urandom_range(3) == 0)
            op = OP_INSERT_EMPTY;
          // aim at a legal position
          if (op == OP_INSERT || op == OP_INSERT_EMPTY)
            pos = POS_W'($urandom_range(fill_now));
          else if (fill_now > 0)
            pos = POS_W'($urandom_range(fill_now - 1));
          else
            pos = POS_W'($urandom_range(31));
        end
        send(op, pos, val);
      end
    end
    cmd_valid <= 1'b0;

    // Drain outstanding responses, then watch for strays
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d response words never arrived", sb.pending()));

    if (sb.errors == 0)
      $display("tb_indexed_insert_remove_list passed");
    else
      $display("tb_indexed_insert_remove_list failed");
    $finish;
  end

endmodule
